[rtl/fpid_pkg.sv]
// shared widths, register indexes, reset values and command types for the filtered pid core
package fpid_pkg;

  localparam int SMP_W      = 12;  // sample field width
  localparam int SM_W       = 28;  // smoothed value, unsigned q12.16
  localparam int ERR_W      = 29;  // error, signed q12.16
  localparam int DIFF_W     = 30;  // error difference
  localparam int ISUM_W     = 31;  // integral sum, signed q14.16
  localparam int ALPHA_W    = 17;
  localparam int GAIN_W     = 32;
  localparam int MA_W       = 33;  // multiplier operand a, signed
  localparam int MB_W       = 30;  // multiplier operand b, signed
  localparam int PROD_W     = MA_W + MB_W;
  localparam int TOT_W      = 48;
  localparam int DRIVE_W    = 13;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int DEF_SAMPLE_BITS  = 12;
  localparam int DEF_OUTPUT_LIMIT = 4096;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SP_SMOOTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MV_SMOOTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DER_GAIN  = 3'd4;

  localparam logic [ALPHA_W-1:0] RST_SP_SMOOTH = 17'd22;
  localparam logic [ALPHA_W-1:0] RST_MV_SMOOTH = 17'd5958;
  localparam logic [GAIN_W-1:0]  RST_PROP_GAIN = 32'd327680;
  localparam logic [GAIN_W-1:0]  RST_INT_GAIN  = 32'd2147484;
  localparam logic [GAIN_W-1:0]  RST_DER_GAIN  = 32'd0;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  // multiplier operand selects
  localparam logic [2:0] MUL_SP = 3'd0;
  localparam logic [2:0] MUL_MV = 3'd1;
  localparam logic [2:0] MUL_I  = 3'd2;
  localparam logic [2:0] MUL_P  = 3'd3;
  localparam logic [2:0] MUL_D  = 3'd4;

  typedef struct packed {
    logic       load_in;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       upd_sp;
    logic       upd_mv;
    logic       ld_err;
    logic       ld_ediff;
    logic       upd_int;
    logic       ld_total;
    logic       ld_out;
  } cmd_t;

endpackage

[rtl/fpid_stream_if.sv]
// valid/ready channels for the sample word and the drive word
interface fpid_in_if;
  import fpid_pkg::*;
  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] setpoint;
  logic [SMP_W-1:0] measured;
  modport source (output valid, output setpoint, output measured, input ready);
  modport sink (input valid, input setpoint, input measured, output ready);
endinterface

interface fpid_out_if;
  import fpid_pkg::*;
  logic               valid;
  logic               ready;
  logic [DRIVE_W-1:0] drive;
  modport source (output valid, output drive, input ready);
  modport sink (input valid, input drive, output ready);
endinterface

[rtl/fpid_datapath.sv]
// config registers, filter and pid state, shared multiplier and output register
module fpid_datapath #(
  parameter int SAMPLE_BITS  = fpid_pkg::DEF_SAMPLE_BITS,
  parameter int OUTPUT_LIMIT = fpid_pkg::DEF_OUTPUT_LIMIT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fpid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpid_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [fpid_pkg::SMP_W-1:0]      in_setpoint,
  input  logic [fpid_pkg::SMP_W-1:0]      in_measured,
  input  fpid_pkg::cmd_t                  cmd,
  output logic [fpid_pkg::DRIVE_W-1:0]    drive
);
  import fpid_pkg::*;

  localparam logic [SMP_W-1:0] SAMPLE_MASK =
    (SAMPLE_BITS >= SMP_W) ? {SMP_W{1'b1}} : SMP_W'((1 << SAMPLE_BITS) - 1);
  localparam logic signed [PROD_W-1:0] HALF16 = {{(PROD_W-16){1'b0}}, 16'h8000};
  localparam logic signed [PROD_W-1:0] HALF32 = {{(PROD_W-32){1'b0}}, 32'h8000_0000};
  localparam logic signed [31:0] ILIM = 32'sd536870912;
  localparam logic signed [TOT_W-1:0] LIMIT_Q = TOT_W'(OUTPUT_LIMIT) << FRAC_W;
  localparam logic [DRIVE_W-1:0] DRIVE_LIM = DRIVE_W'(OUTPUT_LIMIT);

  logic [ALPHA_W-1:0] alpha_sp_r, alpha_mv_r;
  logic [GAIN_W-1:0]  kp_r, ki_r, kd_r;

  logic [SMP_W-1:0]               sp_r, mv_r;
  logic [SM_W-1:0]                ssp_r, smv_r;
  logic signed [ERR_W-1:0]        e_r, prev_r;
  logic signed [DIFF_W-1:0]       ediff_r;
  logic signed [ISUM_W-1:0]       isum_r, isum_nxt;
  logic signed [PROD_W-1:0]       prod_r, prod_nxt;
  logic signed [TOT_W-1:0]        total_r, total_nxt, tot_fin;
  logic [DRIVE_W-1:0]             drive_r, drive_nxt;

  logic [ALPHA_W-1:0]      a_sp, a_mv;
  logic signed [ERR_W-1:0] d_sp, d_mv, e_nxt;
  logic signed [MA_W-1:0]  ma;
  logic signed [MB_W-1:0]  mb;
  logic signed [PROD_W-1:0] rnd16, rnd32;
  logic signed [31:0]      isum_sum;
  logic [SM_W-1:0]         ssp_nxt, smv_nxt;
  logic [ERR_W-1:0]        ssp_sum, smv_sum;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_sp_r <= RST_SP_SMOOTH;
      alpha_mv_r <= RST_MV_SMOOTH;
      kp_r       <= RST_PROP_GAIN;
      ki_r       <= RST_INT_GAIN;
      kd_r       <= RST_DER_GAIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SP_SMOOTH: alpha_sp_r <= cfg_data[ALPHA_W-1:0];
        CFG_MV_SMOOTH: alpha_mv_r <= cfg_data[ALPHA_W-1:0];
        CFG_PROP_GAIN: kp_r <= cfg_data;
        CFG_INT_GAIN:  ki_r <= cfg_data;
        CFG_DER_GAIN:  kd_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    // coefficient above one acts as one
    a_sp = alpha_sp_r[ALPHA_W-1] ? ALPHA_ONE : alpha_sp_r;
    a_mv = alpha_mv_r[ALPHA_W-1] ? ALPHA_ONE : alpha_mv_r;
    d_sp = $signed({1'b0, sp_r, {FRAC_W{1'b0}}}) - $signed({1'b0, ssp_r});
    d_mv = $signed({1'b0, mv_r, {FRAC_W{1'b0}}}) - $signed({1'b0, smv_r});

    case (cmd.mul_sel)
      MUL_SP: begin
        ma = $signed({{(MA_W-ALPHA_W){1'b0}}, a_sp});
        mb = $signed({d_sp[ERR_W-1], d_sp});
      end
      MUL_MV: begin
        ma = $signed({{(MA_W-ALPHA_W){1'b0}}, a_mv});
        mb = $signed({d_mv[ERR_W-1], d_mv});
      end
      MUL_I: begin
        ma = $signed({1'b0, ki_r});
        mb = $signed({e_r[ERR_W-1], e_r});
      end
      MUL_P: begin
        ma = $signed({1'b0, kp_r});
        mb = $signed({e_r[ERR_W-1], e_r});
      end
      MUL_D: begin
        ma = $signed({1'b0, kd_r});
        mb = ediff_r;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod_nxt = PROD_W'(ma) * PROD_W'(mb);

    // round half up, then floor
    rnd16 = (prod_r + HALF16) >>> FRAC_W;
    rnd32 = (prod_r + HALF32) >>> 32;

    ssp_sum = {1'b0, ssp_r} + rnd16[ERR_W-1:0];
    smv_sum = {1'b0, smv_r} + rnd16[ERR_W-1:0];
    ssp_nxt = ssp_sum[SM_W-1:0];
    smv_nxt = smv_sum[SM_W-1:0];
    e_nxt   = $signed({1'b0, ssp_r}) - $signed({1'b0, smv_r});

    isum_sum = $signed({isum_r[ISUM_W-1], isum_r}) + $signed(rnd32[31:0]);
    if (ki_r == '0) begin
      isum_nxt = '0;
    end else if (isum_sum > ILIM) begin
      isum_nxt = ISUM_W'(ILIM);
    end else if (isum_sum < -ILIM) begin
      isum_nxt = ISUM_W'(-ILIM);
    end else begin
      isum_nxt = isum_sum[ISUM_W-1:0];
    end

    total_nxt = $signed({{(TOT_W-ISUM_W){isum_r[ISUM_W-1]}}, isum_r})
              + $signed(rnd16[TOT_W-1:0]);
    tot_fin   = total_r + $signed(rnd16[TOT_W-1:0]);

    if (tot_fin > LIMIT_Q) begin
      drive_nxt = DRIVE_LIM;
    end else if (tot_fin < 0) begin
      drive_nxt = '0;
    end else begin
      drive_nxt = tot_fin[FRAC_W +: DRIVE_W];
    end
  end

  // loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ssp_r  <= '0;
      smv_r  <= '0;
      isum_r <= '0;
      prev_r <= '0;
    end else begin
      if (cmd.upd_sp) begin
        ssp_r <= ssp_nxt;
      end
      if (cmd.upd_mv) begin
        smv_r <= smv_nxt;
      end
      if (cmd.upd_int) begin
        isum_r <= isum_nxt;
      end
      if (cmd.ld_total) begin
        prev_r <= e_r;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sp_r <= in_setpoint & SAMPLE_MASK;
      mv_r <= in_measured & SAMPLE_MASK;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.ld_err) begin
      e_r <= e_nxt;
    end
    if (cmd.ld_ediff) begin
      ediff_r <= $signed({e_r[ERR_W-1], e_r}) - $signed({prev_r[ERR_W-1], prev_r});
    end
    if (cmd.ld_total) begin
      total_r <= total_nxt;
    end
    if (cmd.ld_out) begin
      drive_r <= drive_nxt;
    end
  end

  assign drive = drive_r;

  a_isum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ($signed({isum_r[ISUM_W-1], isum_r}) <= ILIM) &&
    ($signed({isum_r[ISUM_W-1], isum_r}) >= -ILIM))
    else $error("integral sum outside saturation bounds");

endmodule

[rtl/fpid_ctrl.sv]
// sequencer that steps one sample word through the shared multiplier
module fpid_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output fpid_pkg::cmd_t cmd
);
  import fpid_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MSP  = 4'd1;
  localparam logic [3:0] ST_MMV  = 4'd2;
  localparam logic [3:0] ST_UMV  = 4'd3;
  localparam logic [3:0] ST_ERR  = 4'd4;
  localparam logic [3:0] ST_MI   = 4'd5;
  localparam logic [3:0] ST_MP   = 4'd6;
  localparam logic [3:0] ST_MD   = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_nxt = ST_MSP;
        end
      end
      ST_MSP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SP;
        state_nxt   = ST_MMV;
      end
      ST_MMV: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_MV;
        cmd.upd_sp  = 1'b1;
        state_nxt   = ST_UMV;
      end
      ST_UMV: begin
        cmd.upd_mv = 1'b1;
        state_nxt  = ST_ERR;
      end
      ST_ERR: begin
        cmd.ld_err = 1'b1;
        state_nxt  = ST_MI;
      end
      ST_MI: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_I;
        cmd.ld_ediff = 1'b1;
        state_nxt    = ST_MP;
      end
      ST_MP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_P;
        cmd.upd_int = 1'b1;
        state_nxt   = ST_MD;
      end
      ST_MD: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_D;
        cmd.ld_total = 1'b1;
        state_nxt    = ST_FIN;
      end
      ST_FIN: begin
        // wait here while the previous drive word is still unclaimed
        if (out_free) begin
          cmd.ld_out    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_MSP))
    else $error("accepted word did not start the sequence");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_ready) |=> (state_r == ST_FIN))
    else $error("result overwrote an unclaimed drive word");

  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("drive word raised outside the final step");

endmodule

[rtl/filtered_pid_controller_core.sv]
// top level of the filtered pid core: sequencer plus datapath
//
//  channel  | dir | payload                      | handshake
//  in_chan  | in  | setpoint[11:0] measured[11:0] | valid/ready
//  out_chan | out | drive[12:0]                   | valid/ready
//  cfg_*    | in  | cfg_index[2:0] cfg_data[31:0] | cfg_we, no wait
//
// each word steps through the sequencer states from accept to drive valid; a new word is
// taken in the cycle after the drive register loads, so a word is never taken before the
// last one is done. the single shared multiplier handles five products per word.
// synchronous active-low reset clears the filter, integral and previous-error state
// and loads the register defaults. a stalled drive word holds the sequencer
// in its final step until the word is taken.
module filtered_pid_controller_core #(
  parameter int SAMPLE_BITS  = fpid_pkg::DEF_SAMPLE_BITS,
  parameter int OUTPUT_LIMIT = fpid_pkg::DEF_OUTPUT_LIMIT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fpid_in_if.sink                         in_chan,
  fpid_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [fpid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpid_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fpid_pkg::*;

  cmd_t               cmd;
  logic               in_ready;
  logic               out_valid;
  logic [DRIVE_W-1:0] drive;

  fpid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  fpid_datapath #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .OUTPUT_LIMIT (OUTPUT_LIMIT)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_setpoint (in_chan.setpoint),
    .in_measured (in_chan.measured),
    .cmd         (cmd),
    .drive       (drive)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;
  assign out_chan.drive = drive;

endmodule
